FILE: rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, codes and the CRC-16/Modbus byte step for the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET     = 8'h01;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FRAME_LEN = 8;
  localparam int BIDX_W    = $clog2(FRAME_LEN);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Frame body before CRC: bytes 0..5 in transmit order
  typedef struct packed {
    logic [7:0] b5;
    logic [7:0] b4;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] func;
    logic [7:0] addr;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // One byte through the reflected CRC-16/Modbus register
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/modbus_rtu_request_framer_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit
// Modbus RTU master request framer with CRC-16/Modbus.
// ----------------------------------------------------------------------------
// A request word on the s_ side (tuser = operation, tdata = register address
// and value/count) becomes an 8-byte RTU frame on the m_ side: slave address,
// function code (3 read holding, 6 write single), four big-endian field bytes,
// then CRC low and CRC high. m_tlast marks the CRC high byte.
// The slave address comes from slave_address_wdata when slave_address_we is
// high; it is captured with each request as it is accepted.
// A request is written into the queue, then the serializer moves it into the
// output register byte by byte. Throughput: one byte per cycle while m_tready
// is high; frames follow with no gap, set by the single byte-wide serializer.
// A two-entry queue sits between the request side and the serializer, so a
// new request is taken while the previous frame is still going out.
// Reset clears the queue, m_tvalid and the byte index; slave address becomes 1.
// When m_tready is low the current byte holds; once the queue fills s_tready
// drops until the serializer finishes a frame.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        slave_address_we,
  input  logic [7:0]  slave_address_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] register_address, [31:16] value_or_count
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast    // last_byte
);
  import mrf_pkg::*;

  frame_t  body;
  frame_t  head;
  q_ctrl_t qctrl;
  logic    q_not_empty;
  logic    q_full;
  logic    pop;
  logic    accept;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign qctrl.push = accept;
  assign qctrl.pop  = pop;

  mrf_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .slave_address_we     (slave_address_we),
    .slave_address_wdata  (slave_address_wdata),
    .req_op               (s_tuser),
    .req_register_address (s_tdata[15:0]),
    .req_value_or_count   (s_tdata[31:16]),
    .body                 (body)
  );

  mrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qctrl),
    .wr_data   (body),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Holds the slave address and turns an accepted request into a frame body.
// ----------------------------------------------------------------------------
module mrf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             slave_address_we,
  input  logic [7:0]       slave_address_wdata,
  input  logic             req_op,
  input  logic [15:0]      req_register_address,
  input  logic [15:0]      req_value_or_count,
  output mrf_pkg::frame_t  body
);
  import mrf_pkg::*;

  logic [7:0] slave_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_RESET;
    end else if (slave_address_we) begin
      slave_address <= slave_address_wdata;
    end
  end

  always_comb begin
    body.addr = slave_address;
    body.b3   = req_register_address[7:0];
    body.b4   = req_value_or_count[15:8];
    body.b5   = req_value_or_count[7:0];
    // write single sends a zero high address byte
    if (op_t'(req_op) == OP_WRITE) begin
      body.func = FC_WRITE_SINGLE;
      body.b2   = 8'h00;
    end else begin
      body.func = FC_READ_HOLDING;
      body.b2   = req_register_address[15:8];
    end
  end

endmodule

FILE: rtl/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// Short FIFO of frame bodies between the front and the serializer.
// ----------------------------------------------------------------------------
module mrf_queue (
  input  logic             clk,
  input  logic             rst,
  input  mrf_pkg::q_ctrl_t ctrl,
  input  mrf_pkg::frame_t  wr_data,
  output mrf_pkg::frame_t  head,
  output logic             not_empty,
  output logic             full
);
  import mrf_pkg::*;

  frame_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (!ctrl.push && ctrl.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Serializes the queue head one byte per word, folding each body byte into
// the CRC and appending the CRC low then high byte.
// ----------------------------------------------------------------------------
module mrf_back (
  input  logic            clk,
  input  logic            rst,
  input  mrf_pkg::frame_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import mrf_pkg::*;

  logic [BIDX_W-1:0] idx;
  logic [15:0]       crc;
  logic [15:0]       crc_cur;
  logic [7:0]        byte_sel;
  logic              advance;
  logic              fire;
  logic              is_last;

  assign advance = !m_tvalid || m_tready;
  assign fire    = advance && head_valid;
  assign is_last = (idx == BIDX_W'(FRAME_LEN - 1));
  assign pop     = fire && is_last;
  assign crc_cur = (idx == '0) ? CRC_INIT : crc;

  always_comb begin
    case (idx)
      3'd0:    byte_sel = head.addr;
      3'd1:    byte_sel = head.func;
      3'd2:    byte_sel = head.b2;
      3'd3:    byte_sel = head.b3;
      3'd4:    byte_sel = head.b4;
      3'd5:    byte_sel = head.b5;
      3'd6:    byte_sel = crc[7:0];
      default: byte_sel = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else if (fire) begin
      idx      <= is_last ? '0 : idx + 1'b1;
      m_tvalid <= 1'b1;
    end else if (advance) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload: crc only advances over the six body bytes
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= byte_sel;
      m_tlast <= is_last;
      if (idx < BIDX_W'(6)) begin
        crc <= crc_step(crc_cur, byte_sel);
      end
    end
  end

endmodule

FILE: tb/modbus_rtu_request_framer_unit_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit_test
// Self-checking bench for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
// Requests are fed from a queue through a clocked driver. Each accepted word
// is turned into the eight expected frame bytes (address, function code,
// fields, CRC-16/Modbus) by a local predictor. A clocked monitor compares
// every output byte and its tlast flag in order. The run covers directed
// corner requests, then random requests under three idle patterns and
// several slave addresses (reset value, 0xff, 0x00, random).
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit_test;
  import mrf_pkg::*;

  typedef struct {
    op_t         op;
    logic [15:0] reg_addr;
    logic [15:0] val;
  } request_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        slave_address_we = 1'b0;
  logic [7:0]  slave_address_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] register_address, [31:16] value_or_count
  logic        s_tuser = 1'b0; // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] frame_byte
  logic        m_tlast;

  request_t    req_q[$];
  request_t    req_cur;
  frame_word_t frame_exp_q[$];
  logic [7:0]  slave_addr_cfg = SLAVE_RESET;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          n_requests = 0;
  int          n_bytes = 0;
  int          n_errors = 0;

  modbus_rtu_request_framer_unit u_top (
    .clk                 (clk),
    .rst                 (rst),
    .slave_address_we    (slave_address_we),
    .slave_address_wdata (slave_address_wdata),
    .s_tvalid            (s_tvalid),
    .s_tready            (s_tready),
    .s_tdata             (s_tdata),
    .s_tuser             (s_tuser),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata),
    .m_tlast             (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected frame for one request, using the slave address in force now
  function automatic void predict_frame(request_t r);
    logic [7:0]  fb [8];
    logic [15:0] crc;
    frame_word_t w;
    fb[0] = slave_addr_cfg;
    if (r.op == OP_READ) begin
      fb[1] = FC_READ_HOLDING;
      fb[2] = r.reg_addr[15:8];
    end else begin
      fb[1] = FC_WRITE_SINGLE;
      fb[2] = 8'h00;   // write carries only an 8-bit register index
    end
    fb[3] = r.reg_addr[7:0];
    fb[4] = r.val[15:8];
    fb[5] = r.val[7:0];
    crc = CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      crc = crc ^ {8'h00, fb[k]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int k = 0; k < 8; k++) begin
      w.data = fb[k];
      w.last = (k == 7);
      frame_exp_q.push_back(w);
    end
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void add_req(op_t op, logic [15:0] a, logic [15:0] v);
    request_t r;
    r.op = op;
    r.reg_addr = a;
    r.val = v;
    req_q.push_back(r);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: begin
        return 16'h0000;
      end
      1: begin
        return 16'hffff;
      end
      2: begin
        return 16'($urandom_range(0, 255));
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic void add_random(int n);
    for (int i = 0; i < n; i++) begin
      add_req(op_t'($urandom_range(0, 1)), rand_field(), rand_field());
    end
  endfunction

  // Only called with nothing in flight
  task automatic set_slave_address(logic [7:0] v);
    @(posedge clk);
    slave_address_we <= 1'b1;
    slave_address_wdata <= v;
    @(posedge clk);
    slave_address_we <= 1'b0;
    slave_addr_cfg = v;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || s_tvalid || frame_exp_q.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_frame(req_cur);
        n_requests++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          req_cur = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {req_cur.val, req_cur.reg_addr};
          s_tuser <= req_cur.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // frame monitor: one word per accepted byte
  always @(posedge clk) begin
    frame_word_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_bytes++;
        if (frame_exp_q.size() == 0) begin
          note_error($sformatf("unexpected word data=%02h last=%0b", m_tdata, m_tlast));
        end else begin
          w = frame_exp_q.pop_front();
          if (m_tdata !== w.data || m_tlast !== w.last) begin
            note_error($sformatf("word %0d: expected data=%02h last=%0b, got data=%02h last=%0b",
                                 n_bytes, w.data, w.last, m_tdata, m_tlast));
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    logic [7:0] mid_addr;
    mid_addr = 8'($urandom_range(2, 254));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners with the reset slave address
    gap_pct = 38;
    stall_pct = 45;
    add_req(OP_READ,  16'h0000, 16'h0000);
    add_req(OP_READ,  16'hffff, 16'hffff);
    add_req(OP_WRITE, 16'h0000, 16'h0000);
    add_req(OP_WRITE, 16'hffff, 16'hffff);   // upper address bits dropped
    add_req(OP_WRITE, 16'hab80, 16'h8000);
    add_req(OP_READ,  16'h0001, 16'h007d);
    add_req(OP_READ,  16'h00ff, 16'hff00);
    add_req(OP_WRITE, 16'hff00, 16'h0001);
    add_req(OP_READ,  16'h5555, 16'haaaa);
    add_req(OP_WRITE, 16'haaaa, 16'h5555);
    add_req(OP_READ,  16'h8000, 16'h0001);
    add_req(OP_WRITE, 16'h1234, 16'h00ff);
    add_random(40);
    drain();

    set_slave_address(8'hff);
    add_random(35);
    drain();

    gap_pct = 45;
    stall_pct = 38;
    set_slave_address(8'h00);
    add_random(40);
    drain();

    gap_pct = 0;
    stall_pct = 0;
    set_slave_address(mid_addr);
    add_random(35);
    drain();

    $display("tb: %0d requests framed, %0d frame words checked, %0d mismatches",
             n_requests, n_bytes, n_errors);
    $display("tb: slave addresses 01, ff, 00, %02h; both function codes", mid_addr);
    if (n_errors == 0 && frame_exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
